// ===== sv/xce_pkg.sv =====
// shared types and constants of the xml character escaper
package xce_pkg;

    // longest escaped form, as in "&quot;" or "&#200;"
    localparam int unsigned MAX_LEN = 6;
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_LEN);

    // depth of the queue between classifier and serializer
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [7:0] char_t;

    // one fully formatted escape sequence, first byte in text[0]
    typedef struct packed {
        logic [LEN_W-1:0]          len;
        logic [MAX_LEN-1:0][7:0]   text;
    } esc_word_t;

endpackage

// ===== sv/xce_front.sv =====
// classifier: turns one source byte into its formatted escape sequence
module xce_front
(
    input  xce_pkg::char_t    in_char,
    input  logic [7:0]        keep_below,
    output logic              is_term,
    output xce_pkg::esc_word_t word_out
);

    localparam logic [7:0] CH_AMP   = 8'd38;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_QUOT  = 8'd34;
    localparam logic [7:0] CH_APOS  = 8'd39;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;

    logic        keep_raw;
    logic        use_dec;
    logic [1:0]  hundreds;
    logic [6:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [7:0]  ch_h;
    logic [7:0]  ch_t;
    logic [7:0]  ch_o;

    assign is_term  = (in_char == 8'd0);
    assign keep_raw = (in_char < 8'd128) && (in_char < keep_below);
    assign use_dec  = (in_char < 8'd32) || (in_char >= 8'd127);

    // decimal digits: hundreds by compare, tens by reciprocal multiply
    always_comb
    begin
        if (in_char >= 8'd200)
        begin
            hundreds = 2'd2;
            rem_h    = 7'(in_char - 8'd200);
        end
        else if (in_char >= 8'd100)
        begin
            hundreds = 2'd1;
            rem_h    = 7'(in_char - 8'd100);
        end
        else
        begin
            hundreds = 2'd0;
            rem_h    = in_char[6:0];
        end
        tens_prod = 15'(rem_h) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = 4'(rem_h - 7'(tens) * 7'd10);
        ch_h      = CH_ZERO + 8'(hundreds);
        ch_t      = CH_ZERO + 8'(tens);
        ch_o      = CH_ZERO + 8'(ones);
    end

    always_comb
    begin
        word_out.len  = '0;
        word_out.text = '0;
        if (keep_raw)
        begin
            word_out.len     = xce_pkg::LEN_W'(1);
            word_out.text[0] = in_char;
        end
        else if (use_dec)
        begin
            word_out.text[0] = CH_AMP;
            word_out.text[1] = CH_HASH;
            if (in_char >= 8'd100)
            begin
                word_out.len     = xce_pkg::LEN_W'(6);
                word_out.text[2] = ch_h;
                word_out.text[3] = ch_t;
                word_out.text[4] = ch_o;
                word_out.text[5] = CH_SEMI;
            end
            else if (in_char >= 8'd10)
            begin
                word_out.len     = xce_pkg::LEN_W'(5);
                word_out.text[2] = ch_t;
                word_out.text[3] = ch_o;
                word_out.text[4] = CH_SEMI;
            end
            else
            begin
                word_out.len     = xce_pkg::LEN_W'(4);
                word_out.text[2] = ch_o;
                word_out.text[3] = CH_SEMI;
            end
        end
        else
        begin
            unique case (in_char)
                CH_QUOT:
                begin
                    word_out.len  = xce_pkg::LEN_W'(6);
                    word_out.text = {8'd59, 8'd116, 8'd111, 8'd117, 8'd113, 8'd38};
                end
                CH_AMP:
                begin
                    word_out.len  = xce_pkg::LEN_W'(5);
                    word_out.text = {8'd0, 8'd59, 8'd112, 8'd109, 8'd97, 8'd38};
                end
                CH_APOS:
                begin
                    word_out.len  = xce_pkg::LEN_W'(5);
                    word_out.text = {8'd0, 8'd59, 8'd57, 8'd51, 8'd35, 8'd38};
                end
                CH_LT:
                begin
                    word_out.len  = xce_pkg::LEN_W'(4);
                    word_out.text = {8'd0, 8'd0, 8'd59, 8'd116, 8'd108, 8'd38};
                end
                CH_GT:
                begin
                    word_out.len  = xce_pkg::LEN_W'(4);
                    word_out.text = {8'd0, 8'd0, 8'd59, 8'd116, 8'd103, 8'd38};
                end
                default:
                begin
                    word_out.len     = xce_pkg::LEN_W'(1);
                    word_out.text[0] = in_char;
                end
            endcase
        end
    end

endmodule

// ===== sv/xce_queue.sv =====
// small flop queue of formatted escape sequences
module xce_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  xce_pkg::esc_word_t push_word,
    input  logic               pop,
    output xce_pkg::esc_word_t head_word,
    output logic               not_empty,
    output logic               full
);

    localparam int unsigned DEPTH = xce_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xce_pkg::esc_word_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/xce_back.sv =====
// serializer: walks the head sequence into an output register, one byte per cycle unless out_ready stalls it
module xce_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  xce_pkg::esc_word_t head_word,
    input  logic               head_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output xce_pkg::char_t     out_char,
    output logic               out_last
);

    logic [xce_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    xce_pkg::char_t            char_reg;
    logic                      last_reg;
    logic                      load;
    logic                      at_last;

    // output register may take a new byte when empty or being drained
    assign load    = (!valid_reg || out_ready) && head_valid;
    assign at_last = (xce_pkg::LEN_W'(idx_reg) == head_word.len - 1'b1);
    assign pop     = load && at_last;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head_word.text[idx_reg];
            last_reg <= at_last;
        end
    end

    a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (xce_pkg::LEN_W'(idx_reg) < head_word.len))
        else $error("byte index past end of sequence");

    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == '0))
        else $error("byte index not at start with queue empty");

endmodule

// ===== sv/xml_character_escaper.sv =====
// top level of the xml character escaper
//
// Takes one text byte per input word and returns its XML-escaped form as one to six
// output words, the final one flagged with m_tlast. A byte b with 1 <= b < keep_below
// (and b below 128) passes raw; otherwise control bytes 1..31 and 127 become "&#n;",
// the quote, ampersand, apostrophe, less-than and greater-than signs become "&quot;",
// "&amp;", "&#39;", "&lt;" and "&gt;", bytes 128..255 become "&#nnn;", and every other
// byte passes as it is. Byte 0 is a terminator: it is accepted and produces no output.
// A plain byte yields one output byte, an escaped byte up to six, and a terminator none;
// the serializer, which drives one output byte per cycle from the head of a two-entry
// queue while m_tready does not stall it, sets the output rate. The classifier in front
// takes a new byte every cycle while the queue has room, so input and output stall
// independently. keep_below is written through cfg_wr_en/cfg_wr_data and resets to 0;
// write it only while the block is idle.
module xml_character_escaper
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,   // keep_below
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tlast        // last_of_run
);

    logic [7:0]         keep_below_reg;

    logic               is_term;
    xce_pkg::esc_word_t front_word;

    logic               q_push;
    logic               q_pop;
    logic               q_not_empty;
    logic               q_full;
    xce_pkg::esc_word_t q_head;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_below_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            keep_below_reg <= cfg_wr_data;
        end
    end

    // front: classify and format the incoming byte
    xce_front u_front
    (
        .in_char    (s_tdata),
        .keep_below (keep_below_reg),
        .is_term    (is_term),
        .word_out   (front_word)
    );

    // terminators are consumed here and never reach the queue
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && !is_term;

    xce_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (front_word),
        .pop       (q_pop),
        .head_word (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // back: serialize the head sequence onto the output stream
    xce_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_word  (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

    // a sequence leaves the queue only with its final byte
    a_pop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_tvalid && m_tlast))
        else $error("sequence retired without a final byte");

endmodule
